@@ rtl/rotation_vector_to_matrix_macros.svh @@
// ----------------------------------------------------------------------------
// Rotation vector to matrix assertion macros
// Concurrent checks sampled on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ROTATION_VECTOR_TO_MATRIX_MACROS_SVH
`define ROTATION_VECTOR_TO_MATRIX_MACROS_SVH

// Same-cycle implication.
`define RVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked a fixed number of cycles later.
`define RVM_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

@@ rtl/rvm_pkg.sv @@
// ----------------------------------------------------------------------------
// Rotation vector to matrix package
// Shared types, constants and arithmetic step functions.
// ----------------------------------------------------------------------------
package rvm_pkg;

  // accept edge to result edge
  localparam int unsigned LATENCY = 44;

  localparam int unsigned N_TERMS = 6;

  // pi/2 in unsigned Q.32 and its multiples
  localparam logic [32:0] HALF_PI = 33'd6746518852;
  localparam logic [32:0] QTR_PI  = 33'd3373259426;
  localparam logic [34:0] HALF_PI_MUL [N_TERMS] = '{
    35'd0, 35'd6746518852, 35'd13493037704,
    35'd20239556556, 35'd26986075408, 35'd33732594260
  };

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // Series divisors as exact reciprocals: floor(a/d) = (a*ceil(2^s/d)) >> s
  localparam logic [32:0] SIN_RCP [N_TERMS] = '{
    33'(((64'd1 << 40) + 64'd155) / 64'd156),
    33'(((64'd1 << 39) + 64'd109) / 64'd110),
    33'(((64'd1 << 39) + 64'd71) / 64'd72),
    33'(((64'd1 << 38) + 64'd41) / 64'd42),
    33'(((64'd1 << 37) + 64'd19) / 64'd20),
    33'(((64'd1 << 35) + 64'd5) / 64'd6)
  };
  localparam logic [5:0] SIN_SHF [N_TERMS] = '{
    6'd40, 6'd39, 6'd39, 6'd38, 6'd37, 6'd35
  };
  localparam logic [32:0] COS_RCP [N_TERMS] = '{
    33'(((64'd1 << 40) + 64'd131) / 64'd132),
    33'(((64'd1 << 39) + 64'd89) / 64'd90),
    33'(((64'd1 << 38) + 64'd55) / 64'd56),
    33'(((64'd1 << 37) + 64'd29) / 64'd30),
    33'(((64'd1 << 36) + 64'd11) / 64'd12),
    33'(((64'd1 << 33) + 64'd1) / 64'd2)
  };
  localparam logic [5:0] COS_SHF [N_TERMS] = '{
    6'd40, 6'd39, 6'd38, 6'd37, 6'd36, 6'd33
  };

  typedef logic signed [34:0] qv_t;
  localparam qv_t ONE_Q30 = 35'sd1073741824;

  typedef struct packed {
    logic        sgn;
    logic [63:0] mag;
  } mprod_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
  } div_t;

  // First half of a rounded Q.30 product: magnitudes and sign.
  function automatic mprod_t mq_start(qv_t a, qv_t b);
    logic [34:0] ma;
    logic [34:0] mb;
    mprod_t      p;
    ma    = a[34] ? 35'(-a) : 35'(a);
    mb    = b[34] ? 35'(-b) : 35'(b);
    p.sgn = a[34] ^ b[34];
    p.mag = 64'(ma[31:0]) * 64'(mb[31:0]);
    return p;
  endfunction

  // Second half: round half away from zero and apply the sign.
  function automatic qv_t mq_round(mprod_t p);
    logic [63:0] t;
    qv_t         r;
    t = p.mag + 64'd536870912;
    r = qv_t'({1'b0, t[63:30]});
    return p.sgn ? -r : r;
  endfunction

  // One digit of the integer square root; k selects the bit weight.
  function automatic sqrt_t sqrt_step(sqrt_t s, int unsigned k);
    logic [63:0] bitv;
    logic [63:0] trial;
    sqrt_t       o;
    bitv  = 64'd1 << (62 - 2 * k);
    trial = s.res + bitv;
    if (s.n >= trial) begin
      o.n   = s.n - trial;
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.n   = s.n;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // One quotient bit of restoring division.
  function automatic div_t div_step(div_t s, logic [31:0] dvs);
    logic [32:0] tmp;
    div_t        o;
    tmp   = {s.rem, s.low[31]};
    o.low = {s.low[30:0], 1'b0};
    if (tmp >= {1'b0, dvs}) begin
      o.rem = 32'(tmp - {1'b0, dvs});
      o.quo = {s.quo[30:0], 1'b1};
    end else begin
      o.rem = tmp[31:0];
      o.quo = {s.quo[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [31:0] sat_q30(logic signed [35:0] v);
    if (v > 36'sd1073741824) begin
      return 32'h4000_0000;
    end else if (v < -36'sd1073741824) begin
      return 32'hC000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [35:0] sx36(qv_t v);
    return {v[34], v};
  endfunction

endpackage

@@ rtl/rvm_sincos.sv @@
// ----------------------------------------------------------------------------
// Rotation vector to matrix sine/cosine pipeline
// Quadrant reduction and nested series for an unsigned Q.32 angle, 18 stages.
// ----------------------------------------------------------------------------
module rvm_sincos
  import rvm_pkg::*;
(
  input  logic        clk_i,
  input  logic [34:0] h_i,
  output qv_t         sin_o,
  output qv_t         cos_o
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] x2;
    logic        swp;
    logic [2:0]  quad;
  } side_t;

  logic [34:0] h1_q;
  logic [2:0]  q1_q;
  logic [2:0]  qc;
  logic [32:0] m2_q;
  logic [2:0]  q2_q;
  logic [31:0] x3_q;
  logic        swp3_q;
  logic [2:0]  q3_q;
  logic [63:0] xx;
  side_t       sd_q [2*N_TERMS+1];
  logic [31:0] as_q [N_TERMS];
  logic [31:0] ac_q [N_TERMS];
  logic [32:0] ts_q [N_TERMS];
  logic [32:0] tc_q [N_TERMS];
  logic [31:0] sx17_q;
  logic [32:0] cx17_q;
  logic        swp17_q;
  logic [2:0]  q17_q;
  logic [63:0] sxp;
  logic [32:0] av;
  logic [33:0] bv;
  qv_t         sa;
  qv_t         cb;
  qv_t         sin_q;
  qv_t         cos_q;

  // quadrant count by compare against multiples of pi/2
  always_comb begin
    qc = '0;
    for (int k = 1; k < N_TERMS; k++) begin
      if (h_i >= HALF_PI_MUL[k]) qc = 3'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q   <= h_i;
    q1_q   <= qc;
    m2_q   <= 33'(h1_q - HALF_PI_MUL[q1_q]);
    q2_q   <= q1_q;
    swp3_q <= (m2_q > QTR_PI);
    x3_q   <= (m2_q > QTR_PI) ? 32'(HALF_PI - m2_q) : m2_q[31:0];
    q3_q   <= q2_q;
  end

  assign xx = 64'(x3_q) * 64'(x3_q);

  always_ff @(posedge clk_i) begin
    sd_q[0] <= '{x: x3_q, x2: xx[63:32], swp: swp3_q, quad: q3_q};
  end

  for (genvar i = 0; i < N_TERMS; i++) begin : g_term
    logic [32:0] tsi;
    logic [32:0] tci;
    logic [64:0] ps;
    logic [64:0] pc;
    logic [64:0] rs;
    logic [64:0] rc;

    if (i == 0) begin : g_first
      assign tsi = ONE_Q32;
      assign tci = ONE_Q32;
    end else begin : g_next
      assign tsi = ts_q[i-1];
      assign tci = tc_q[i-1];
    end

    assign ps = 65'(sd_q[2*i].x2) * 65'(tsi);
    assign pc = 65'(sd_q[2*i].x2) * 65'(tci);
    assign rs = (65'(as_q[i]) * 65'(SIN_RCP[i])) >> SIN_SHF[i];
    assign rc = (65'(ac_q[i]) * 65'(COS_RCP[i])) >> COS_SHF[i];

    always_ff @(posedge clk_i) begin
      as_q[i]       <= ps[63:32];
      ac_q[i]       <= pc[63:32];
      sd_q[2*i+1]   <= sd_q[2*i];
      ts_q[i]       <= ONE_Q32 - 33'(rs);
      tc_q[i]       <= ONE_Q32 - 33'(rc);
      sd_q[2*i+2]   <= sd_q[2*i+1];
    end
  end

  assign sxp = 64'(sd_q[2*N_TERMS].x) * 64'(ts_q[N_TERMS-1]);

  always_ff @(posedge clk_i) begin
    sx17_q  <= sxp[63:32];
    cx17_q  <= tc_q[N_TERMS-1];
    swp17_q <= sd_q[2*N_TERMS].swp;
    q17_q   <= sd_q[2*N_TERMS].quad;
  end

  // Q.32 to Q.30 with rounding, then fold back to the full circle
  always_comb begin
    av = (33'(sx17_q) + 33'd2) >> 2;
    bv = (34'(cx17_q) + 34'd2) >> 2;
    sa = swp17_q ? qv_t'({1'b0, bv}) : qv_t'({2'b0, av});
    cb = swp17_q ? qv_t'({2'b0, av}) : qv_t'({1'b0, bv});
  end

  always_ff @(posedge clk_i) begin
    case (q17_q[1:0])
      2'd0: begin
        sin_q <= sa;
        cos_q <= cb;
      end
      2'd1: begin
        sin_q <= cb;
        cos_q <= -sa;
      end
      2'd2: begin
        sin_q <= -sa;
        cos_q <= -cb;
      end
      default: begin
        sin_q <= -cb;
        cos_q <= sa;
      end
    endcase
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

@@ rtl/rotation_vector_to_matrix.sv @@
// Throughput: one rotation vector per cycle; busy is never raised.
// The 32-digit square root and the 32-bit quotient units set the depth.
// Reset clears only the valid pipeline; results in flight at reset are dropped.
// Results cannot be stalled: done_o marks each matrix for exactly one cycle.
// ----------------------------------------------------------------------------
// Rotation vector to rotation matrix
// Rodrigues' formula in fixed point: norm, unit axis, half-angle sine/cosine.
// ----------------------------------------------------------------------------
`include "rotation_vector_to_matrix_macros.svh"

module rotation_vector_to_matrix
  import rvm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] theta_x_i,
  input  logic [31:0] theta_y_i,
  input  logic [31:0] theta_z_i,
  output logic        done_o,
  output logic [31:0] rot_00_o,
  output logic [31:0] rot_01_o,
  output logic [31:0] rot_02_o,
  output logic [31:0] rot_10_o,
  output logic [31:0] rot_11_o,
  output logic [31:0] rot_12_o,
  output logic [31:0] rot_20_o,
  output logic [31:0] rot_21_o,
  output logic [31:0] rot_22_o
);

  localparam int unsigned SQ_STAGES  = 16;
  localparam int unsigned DIV_STAGES = 16;
  localparam int unsigned CTL_DEPTH  = 23;

  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic [4:0]       e;
  } meta_t;

  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } ctl_t;

  logic [LATENCY-1:0] vld_q;

  logic [2:0][31:0] th;
  logic [2:0][31:0] mag;
  logic [2:0]       neg;
  logic [2:0][31:0] mag1_q;
  logic [2:0]       neg1_q;
  logic [63:0]      sq1_q [3];
  logic [2:0][31:0] mag2_q;
  logic [2:0]       neg2_q;
  logic [63:0]      r2_q;
  logic [1:0]       chunk;
  logic [63:0]      r2c_q;
  meta_t            mt3_q;
  logic [3:0]       lz;
  logic [2:0]       elo;
  logic [63:0]      r2n_q;
  meta_t            mt4_q;
  sqrt_t            sq_q [SQ_STAGES];
  meta_t            mts_q [SQ_STAGES];
  logic [31:0]      rs;
  meta_t            mt_s;
  div_t             dv_q [DIV_STAGES+1][3];
  logic [31:0]      rsd_q [DIV_STAGES+1];
  logic [34:0]      h21_q;
  ctl_t             ctl_q [CTL_DEPTH];
  qv_t              u38_q [3];
  qv_t              u39_q [3];
  qv_t              u40_q [3];
  qv_t              u41_q [3];
  qv_t              sh39;
  qv_t              ch39;
  mprod_t           pa_q [8];
  qv_t              s41_q;
  qv_t              v41_q;
  qv_t              dm41_q [3];
  qv_t              w41_q [3];
  mprod_t           pb_q [9];
  qv_t              rb_q [9];
  logic signed [35:0] rm [9];
  logic [31:0]      rot_q [9];

  assign busy = 1'b0;

  // valid bits travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start && !busy};
    end
  end

  assign th = {theta_z_i, theta_y_i, theta_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i] = th[i][31];
      mag[i] = th[i][31] ? 32'(-th[i]) : th[i];
    end
  end

  // squares, sum
  always_ff @(posedge clk_i) begin
    mag1_q <= mag;
    neg1_q <= neg;
    for (int i = 0; i < 3; i++) begin
      sq1_q[i] <= 64'(mag[i]) * 64'(mag[i]);
    end
    mag2_q <= mag1_q;
    neg2_q <= neg1_q;
    r2_q   <= sq1_q[0] + sq1_q[1] + sq1_q[2];
  end

  // normalize in two steps: whole 16-bit chunks, then bit pairs
  always_comb begin
    if (r2_q[63:48] != '0) begin
      chunk = 2'd0;
    end else if (r2_q[47:32] != '0) begin
      chunk = 2'd1;
    end else if (r2_q[31:16] != '0) begin
      chunk = 2'd2;
    end else begin
      chunk = 2'd3;
    end
  end

  always_comb begin
    lz = '0;
    for (int b = 0; b < 16; b++) begin
      if (r2c_q[48+b]) lz = 4'(15 - b);
    end
    elo = lz[3:1];
  end

  always_ff @(posedge clk_i) begin
    r2c_q     <= r2_q << {chunk, 4'b0000};
    mt3_q.zero <= (r2_q == '0);
    mt3_q.neg <= neg2_q;
    mt3_q.mag <= mag2_q;
    mt3_q.e   <= {chunk, 3'b000};
    r2n_q     <= r2c_q << {elo, 1'b0};
    mt4_q     <= mt3_q;
    mt4_q.e   <= {mt3_q.e[4:3], elo};
  end

  // square root, two digits per stage
  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
    sqrt_t sin_s;
    meta_t min_s;
    if (g == 0) begin : g_first
      assign sin_s = '{n: r2n_q, res: '0};
      assign min_s = mt4_q;
    end else begin : g_next
      assign sin_s = sq_q[g-1];
      assign min_s = mts_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      sq_q[g]  <= sqrt_step(sqrt_step(sin_s, 2 * g), 2 * g + 1);
      mts_q[g] <= min_s;
    end
  end

  assign rs   = sq_q[SQ_STAGES-1].res[31:0];
  assign mt_s = mts_q[SQ_STAGES-1];

  // dividends |theta_i| * 2^(e+30) + rs/2 and half angle h = r/2 in Q.32
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      logic [63:0] dvd;
      dvd = {2'b00, 32'(mt_s.mag[i] << mt_s.e), 30'd0} + 64'(rs[31:1]);
      dv_q[0][i] <= '{rem: dvd[63:32], low: dvd[31:0], quo: '0};
    end
    rsd_q[0] <= rs;
    h21_q    <= {rs, 3'b000} >> mt_s.e;
  end

  always_ff @(posedge clk_i) begin
    ctl_q[0] <= '{zero: mt_s.zero, neg: mt_s.neg};
    for (int k = 1; k < CTL_DEPTH; k++) begin
      ctl_q[k] <= ctl_q[k-1];
    end
  end

  // unit axis quotients, two bits per stage
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_q[g+1][i] <= div_step(div_step(dv_q[g][i], rsd_q[g]), rsd_q[g]);
      end
      rsd_q[g+1] <= rsd_q[g];
    end
  end

  rvm_sincos u_sincos (
    .clk_i (clk_i),
    .h_i   (h21_q),
    .sin_o (sh39),
    .cos_o (ch39)
  );

  // clamp to one, apply sign, align with the sine/cosine output
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      logic [31:0] qv;
      qv = dv_q[DIV_STAGES][i].quo;
      if (qv > 32'h4000_0000) qv = 32'h4000_0000;
      u38_q[i] <= ctl_q[DIV_STAGES].neg[i] ? -qv_t'({3'b000, qv}) : qv_t'({3'b000, qv});
      u39_q[i] <= u38_q[i];
      u40_q[i] <= u39_q[i];
      u41_q[i] <= u40_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q[0] <= mq_start(sh39, ch39);
    pa_q[1] <= mq_start(sh39, sh39);
    pa_q[2] <= mq_start(u39_q[0], u39_q[0]);
    pa_q[3] <= mq_start(u39_q[1], u39_q[1]);
    pa_q[4] <= mq_start(u39_q[2], u39_q[2]);
    pa_q[5] <= mq_start(u39_q[0], u39_q[1]);
    pa_q[6] <= mq_start(u39_q[0], u39_q[2]);
    pa_q[7] <= mq_start(u39_q[1], u39_q[2]);
  end

  always_ff @(posedge clk_i) begin
    qv_t t0;
    qv_t t1;
    t0 = mq_round(pa_q[0]);
    t1 = mq_round(pa_q[1]);
    s41_q <= {t0[33:0], 1'b0};
    v41_q <= {t1[33:0], 1'b0};
    for (int i = 0; i < 3; i++) begin
      dm41_q[i] <= mq_round(pa_q[2+i]) - ONE_Q30;
      w41_q[i]  <= mq_round(pa_q[5+i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pb_q[i]   <= mq_start(v41_q, dm41_q[i]);
      pb_q[3+i] <= mq_start(v41_q, w41_q[i]);
      pb_q[6+i] <= mq_start(s41_q, u41_q[i]);
    end
    for (int k = 0; k < 9; k++) begin
      rb_q[k] <= mq_round(pb_q[k]);
    end
  end

  // terms: 0..2 V*(u_i^2-1), 3 V*u0u1, 4 V*u0u2, 5 V*u1u2, 6..8 S*u_i
  always_comb begin
    rm[0] = sx36(ONE_Q30) + sx36(rb_q[0]);
    rm[4] = sx36(ONE_Q30) + sx36(rb_q[1]);
    rm[8] = sx36(ONE_Q30) + sx36(rb_q[2]);
    rm[1] = sx36(rb_q[3]) - sx36(rb_q[8]);
    rm[3] = sx36(rb_q[3]) + sx36(rb_q[8]);
    rm[2] = sx36(rb_q[4]) + sx36(rb_q[7]);
    rm[6] = sx36(rb_q[4]) - sx36(rb_q[7]);
    rm[5] = sx36(rb_q[5]) - sx36(rb_q[6]);
    rm[7] = sx36(rb_q[5]) + sx36(rb_q[6]);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) begin
      if (ctl_q[CTL_DEPTH-1].zero) begin
        rot_q[k] <= ((k % 4) == 0) ? 32'h4000_0000 : 32'h0000_0000;
      end else begin
        rot_q[k] <= sat_q30(rm[k]);
      end
    end
  end

  assign done_o   = vld_q[LATENCY-1];
  assign rot_00_o = rot_q[0];
  assign rot_01_o = rot_q[1];
  assign rot_02_o = rot_q[2];
  assign rot_10_o = rot_q[3];
  assign rot_11_o = rot_q[4];
  assign rot_12_o = rot_q[5];
  assign rot_20_o = rot_q[6];
  assign rot_21_o = rot_q[7];
  assign rot_22_o = rot_q[8];

  `RVM_ASSERT_DLY(a_latency, start && !busy, LATENCY, done_o, "accepted beat lost")
  `RVM_ASSERT_IMP(a_source, done_o, $past(start, LATENCY), "result without a beat")
  `RVM_ASSERT_DLY(a_identity,
    start && !busy && theta_x_i == '0 && theta_y_i == '0 && theta_z_i == '0,
    LATENCY,
    rot_00_o == 32'h4000_0000 && rot_11_o == 32'h4000_0000 && rot_22_o == 32'h4000_0000
      && rot_01_o == '0 && rot_12_o == '0 && rot_20_o == '0,
    "zero vector not identity")
  `RVM_ASSERT_IMP(a_range, done_o,
    $signed(rot_11_o) <= 32'sd1073741824 && $signed(rot_11_o) >= -32'sd1073741824,
    "entry out of range")

endmodule

@@ verif/tb_rotation_vector_to_matrix.sv @@
// ----------------------------------------------------------------------------
// Rotation vector to matrix testbench
// Drives rotation vectors through the command port and checks every matrix
// against a fixed-point Rodrigues predictor, over phases of sender idling.
// ----------------------------------------------------------------------------
module tb_rotation_vector_to_matrix;
  import rvm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [2:0][31:0] vec_t;
  typedef logic [8:0][31:0] mat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] theta_x_i;
  logic [31:0] theta_y_i;
  logic [31:0] theta_z_i;
  logic        done_o;
  logic [31:0] rot_00_o, rot_01_o, rot_02_o;
  logic [31:0] rot_10_o, rot_11_o, rot_12_o;
  logic [31:0] rot_20_o, rot_21_o, rot_22_o;

  vec_t        pending_vec_q[$];
  mat_t        expected_rot_q[$];
  int unsigned idle_pct;
  int unsigned n_mismatch;
  bit          failed;

  rotation_vector_to_matrix dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .theta_x_i (theta_x_i),
    .theta_y_i (theta_y_i),
    .theta_z_i (theta_z_i),
    .done_o    (done_o),
    .rot_00_o  (rot_00_o),
    .rot_01_o  (rot_01_o),
    .rot_02_o  (rot_02_o),
    .rot_10_o  (rot_10_o),
    .rot_11_o  (rot_11_o),
    .rot_12_o  (rot_12_o),
    .rot_20_o  (rot_20_o),
    .rot_21_o  (rot_21_o),
    .rot_22_o  (rot_22_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Q.30 product, rounded half away from zero
  function automatic longint q30_mul(longint a, longint b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] p;
    longint      r;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    p  = ma * mb;
    r  = longint'((p + 64'd536870912) >> 30);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic logic [31:0] clamp_unit(longint v);
    if (v > 64'sd1073741824) begin
      return 32'h4000_0000;
    end else if (v < -64'sd1073741824) begin
      return 32'hC000_0000;
    end
    return v[31:0];
  endfunction

  function automatic mat_t rodrigues_matrix(vec_t th_in);
    longint unsigned sin_div[6] = '{156, 110, 72, 42, 20, 6};
    longint unsigned cos_div[6] = '{132, 90, 56, 30, 12, 2};
    longint      th[3];
    longint      u[3];
    longint      rm[9];
    logic [63:0] mg[3];
    logic [63:0] r2, n, res, bitv, rs, num, qt, h, qd, m, x, x2, t, sx, cx;
    longint      a, b, tmp, sh, ch, s_v, v_v;
    int unsigned e;
    bit          swap;
    mat_t        out;
    r2 = '0;
    e  = 0;
    for (int i = 0; i < 3; i++) begin
      th[i] = longint'(signed'(th_in[i]));
      mg[i] = (th[i] < 0) ? 64'(-th[i]) : 64'(th[i]);
      r2    = r2 + mg[i] * mg[i];
    end
    if (r2 == 0) begin
      for (int i = 0; i < 9; i++) rm[i] = (i % 4 == 0) ? 64'sd1073741824 : 0;
    end else begin
      while (r2 < (64'd1 << 62)) begin
        r2 = r2 << 2;
        e++;
      end
      n    = r2;
      res  = '0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      rs = res;
      for (int i = 0; i < 3; i++) begin
        num = (mg[i] << e) << 30;
        qt  = (num + rs / 2) / rs;
        if (qt > 64'd1073741824) qt = 64'd1073741824;
        u[i] = (th[i] < 0) ? -longint'(qt) : longint'(qt);
      end
      // half angle sine and cosine, folded into the first octant
      h    = (rs << 3) >> e;
      qd   = h / 64'd6746518852;
      m    = h - qd * 64'd6746518852;
      swap = m > (64'd6746518852 / 2);
      x    = swap ? 64'd6746518852 - m : m;
      x2   = (x * x) >> 32;
      t    = 64'd1 << 32;
      for (int i = 0; i < 6; i++) t = (64'd1 << 32) - ((x2 * t) >> 32) / sin_div[i];
      sx = (x * t) >> 32;
      t  = 64'd1 << 32;
      for (int i = 0; i < 6; i++) t = (64'd1 << 32) - ((x2 * t) >> 32) / cos_div[i];
      cx = t;
      a  = longint'((sx + 2) >> 2);
      b  = longint'((cx + 2) >> 2);
      if (swap) begin
        tmp = a;
        a   = b;
        b   = tmp;
      end
      case (qd[1:0])
        2'd0: begin sh = a;  ch = b;  end
        2'd1: begin sh = b;  ch = -a; end
        2'd2: begin sh = -a; ch = -b; end
        default: begin sh = -b; ch = a; end
      endcase
      s_v   = 2 * q30_mul(sh, ch);
      v_v   = 2 * q30_mul(sh, sh);
      rm[0] = 64'sd1073741824 + q30_mul(v_v, q30_mul(u[0], u[0]) - 64'sd1073741824);
      rm[4] = 64'sd1073741824 + q30_mul(v_v, q30_mul(u[1], u[1]) - 64'sd1073741824);
      rm[8] = 64'sd1073741824 + q30_mul(v_v, q30_mul(u[2], u[2]) - 64'sd1073741824);
      rm[1] = q30_mul(v_v, q30_mul(u[0], u[1])) - q30_mul(s_v, u[2]);
      rm[3] = q30_mul(v_v, q30_mul(u[1], u[0])) + q30_mul(s_v, u[2]);
      rm[2] = q30_mul(v_v, q30_mul(u[0], u[2])) + q30_mul(s_v, u[1]);
      rm[6] = q30_mul(v_v, q30_mul(u[2], u[0])) - q30_mul(s_v, u[1]);
      rm[5] = q30_mul(v_v, q30_mul(u[1], u[2])) - q30_mul(s_v, u[0]);
      rm[7] = q30_mul(v_v, q30_mul(u[2], u[1])) + q30_mul(s_v, u[0]);
    end
    for (int i = 0; i < 9; i++) out[i] = clamp_unit(rm[i]);
    return out;
  endfunction

  // Driver: predict on each accepted beat, then present the next vector.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      theta_x_i <= '0;
      theta_y_i <= '0;
      theta_z_i <= '0;
    end else if (!start || !busy) begin
      if (start) begin
        expected_rot_q.push_back(rodrigues_matrix({theta_z_i, theta_y_i, theta_x_i}));
      end
      if (pending_vec_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        vec_t v;
        v = pending_vec_q.pop_front();
        start     <= 1'b1;
        theta_x_i <= v[0];
        theta_y_i <= v[1];
        theta_z_i <= v[2];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each done beat against the oldest expected matrix.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      mat_t got;
      mat_t want;
      got = {rot_22_o, rot_21_o, rot_20_o, rot_12_o, rot_11_o, rot_10_o,
             rot_02_o, rot_01_o, rot_00_o};
      if (expected_rot_q.size() == 0) begin
        failed = 1'b1;
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected matrix %h", got);
      end else begin
        want = expected_rot_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== want[i]) begin
            failed = 1'b1;
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("rot_%0d%0d mismatch: expected %h got %h", i / 3, i % 3,
                       want[i], got[i]);
            end
          end
        end
      end
    end
  end

  function automatic logic [31:0] rand_comp();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(5))
      0, 1: v = 32'($signed(v) >>> $urandom_range(31));
      2:    v = 32'($signed(v) >>> 2);
      3:    if ($urandom_range(3) == 0) v = '0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic run_phase(int unsigned pct, int unsigned count);
    idle_pct = pct;
    repeat (count) pending_vec_q.push_back({rand_comp(), rand_comp(), rand_comp()});
    while (pending_vec_q.size() > 0 || start || expected_rot_q.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    idle_pct   = 0;
    n_mismatch = 0;
    failed     = 1'b0;
    rst_ni     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: zero, extremes, tiny, near pi, octant edges
    pending_vec_q.push_back({32'h0, 32'h0, 32'h0});
    pending_vec_q.push_back({32'h0, 32'h0, 32'h7FFF_FFFF});
    pending_vec_q.push_back({32'h0, 32'h8000_0000, 32'h0});
    pending_vec_q.push_back({32'h7FFF_FFFF, 32'h0, 32'h0});
    pending_vec_q.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_vec_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_vec_q.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    pending_vec_q.push_back({32'h0, 32'h0, 32'h1});
    pending_vec_q.push_back({32'hFFFF_FFFF, 32'h0, 32'h0});
    pending_vec_q.push_back({32'h1, 32'hFFFF_FFFF, 32'h1});
    pending_vec_q.push_back({32'h0, 32'h3243_F6A9, 32'h0});
    pending_vec_q.push_back({32'hCDBC_0957, 32'h0, 32'h0});
    pending_vec_q.push_back({32'h0, 32'h0, 32'h1921_FB54});
    pending_vec_q.push_back({32'h0C90_FDAA, 32'h0, 32'h0});
    pending_vec_q.push_back({32'h0, 32'h0, 32'h6487_ED51});
    pending_vec_q.push_back({32'h1000_0000, 32'h1000_0000, 32'h1000_0000});
    pending_vec_q.push_back({32'hF000_0000, 32'h1000_0000, 32'hF000_0000});
    pending_vec_q.push_back({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
    pending_vec_q.push_back({32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
    run_phase(0, 500);
    run_phase(62, 450);
    run_phase(0, 450);
    run_phase(25, 450);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (!failed && expected_rot_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ rotation_vector_to_matrix.f @@
+incdir+rtl
rtl/rvm_pkg.sv
rtl/rvm_sincos.sv
rtl/rotation_vector_to_matrix.sv
verif/tb_rotation_vector_to_matrix.sv
